>>> hw/rtl/assert_macros.svh
// assertion macros used by the top level rtl file of the firing strobe block
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted (active low)
`define ASSERT_CLKRST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/pafs_pkg.sv
// shared types and constants of the phase angle firing strobe block
// no dependencies
`default_nettype none

package pafs_pkg;

    localparam int ANGLE_W = 24;
    localparam int FIRE_W  = 25;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE        = 2'd0,
        REG_MIN_ANGLE     = 2'd1,
        REG_MAX_ANGLE     = 2'd2,
        REG_SAMPLE_WINDOW = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic               enable;
        logic [ANGLE_W-1:0] min_angle;
        logic [ANGLE_W-1:0] max_angle;
        logic [ANGLE_W-1:0] sample_window;
    } t_cfg;

    typedef struct packed {
        logic [ANGLE_W-1:0] prev_folded;
        logic               fired_this_cycle;
        logic               prev_strobe;
        logic [FIRE_W-1:0]  last_fire_folded;
        logic [FIRE_W-1:0]  held_fire_angle;
    } t_state;

    typedef struct packed {
        logic               cycle_start;
        logic               period_start;
        logic               fire;
        logic               fired_late;
        logic               fired_between;
        logic [FIRE_W-1:0]  fire_angle;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/pafs_cfg.sv
// configuration register file of the firing strobe block
// depends on pafs_pkg
`default_nettype none

module pafs_cfg
    import pafs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [ANGLE_W-1:0]   i_cfg_wdata,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= 1'b0;
            r_cfg.min_angle     <= '0;
            r_cfg.max_angle     <= '1;
            r_cfg.sample_window <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_ENABLE:        r_cfg.enable        <= i_cfg_wdata[0];
                REG_MIN_ANGLE:     r_cfg.min_angle     <= i_cfg_wdata;
                REG_MAX_ANGLE:     r_cfg.max_angle     <= i_cfg_wdata;
                REG_SAMPLE_WINDOW: r_cfg.sample_window <= i_cfg_wdata;
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> hw/rtl/pafs_calc.sv
// single-pass firing decision: folds the angle, detects cycle and period
// starts, decides the strobe and computes the next state; depends on pafs_pkg
`default_nettype none

module pafs_calc
    import pafs_pkg::*;
#(
    parameter int CYCLE_BITS        = 23,
    parameter int CYCLE_BEGIN_LIMIT = 2097152,
    parameter int CYCLE_END_LIMIT   = 6291456
) (
    input  wire logic [ANGLE_W-1:0] i_phase_angle,
    input  wire logic [ANGLE_W-1:0] i_request_angle,
    input  wire t_cfg               i_cfg,
    input  wire t_state             i_state,
    output t_state                  o_state,
    output t_result                 o_result
);

    localparam logic [FIRE_W-1:0]  CYCLE_ANGLE = FIRE_W'(1) << CYCLE_BITS;
    localparam logic [ANGLE_W-1:0] CYCLE_MASK  = ANGLE_W'(CYCLE_ANGLE - FIRE_W'(1));
    localparam logic [ANGLE_W-1:0] BEGIN_LIM   = ANGLE_W'(CYCLE_BEGIN_LIMIT);
    localparam logic [ANGLE_W-1:0] END_LIM     = ANGLE_W'(CYCLE_END_LIMIT);

    logic [ANGLE_W-1:0] cur;
    logic               prev_end;
    logic               cyc;
    logic               per;
    logic               fired0;
    logic               in_range;
    logic [FIRE_W-1:0]  cur_x;
    logic [FIRE_W-1:0]  next_angle;
    logic               at_end;
    logic [FIRE_W-1:0]  target;
    logic               in_next;
    logic               cur_in_limits;
    logic               late_c;
    logic               between_c;
    logic               strobe;
    logic [FIRE_W-1:0]  fa;
    logic [FIRE_W-1:0]  held_next;

    always_comb begin
        cur      = i_phase_angle & CYCLE_MASK;
        cur_x    = {1'b0, cur};
        prev_end = i_state.prev_folded > END_LIM;
        cyc      = prev_end && (cur < BEGIN_LIM);
        per      = prev_end && (i_phase_angle < BEGIN_LIM);

        // a strobe moved into the coming cycle counts as that cycle's firing
        fired0 = cyc ? (i_state.prev_strobe && (i_state.last_fire_folded >= CYCLE_ANGLE))
                     : i_state.fired_this_cycle;

        in_range = i_cfg.enable && (i_request_angle >= i_cfg.min_angle)
                   && (i_request_angle <= i_cfg.max_angle);

        next_angle = cur_x + {1'b0, i_cfg.sample_window};
        at_end     = next_angle >= CYCLE_ANGLE;

        // request near the cycle start rides over the wrap
        if (at_end && (i_request_angle < BEGIN_LIM)) begin
            target = {1'b0, i_request_angle} + CYCLE_ANGLE;
        end else begin
            target = {1'b0, i_request_angle};
        end
        in_next = target >= CYCLE_ANGLE;

        cur_in_limits = (cur >= i_cfg.min_angle) && (cur <= i_cfg.max_angle);
        late_c        = (i_request_angle <= cur) && cur_in_limits;
        between_c     = (target > cur_x) && (target <= next_angle);

        strobe = in_range && ((!fired0 && (late_c || between_c)) || (in_next && between_c));
        fa     = between_c ? target : cur_x;

        held_next = strobe ? ({1'b0, i_phase_angle} + fa - cur_x) : i_state.held_fire_angle;

        o_state.prev_folded      = cur;
        o_state.fired_this_cycle = strobe ? 1'b1 : fired0;
        o_state.prev_strobe      = strobe;
        o_state.last_fire_folded = strobe ? fa : i_state.last_fire_folded;
        o_state.held_fire_angle  = held_next;

        o_result.cycle_start   = cyc;
        o_result.period_start  = per;
        o_result.fire          = strobe;
        o_result.fired_late    = in_range && late_c;
        o_result.fired_between = in_range && between_c;
        o_result.fire_angle    = held_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/phase_angle_firing_strobe.sv
// top level of the thyristor phase angle firing strobe block
// depends on pafs_pkg, pafs_cfg, pafs_calc and assert_macros.svh
`default_nettype none

// Phase angle firing strobe. Each input beat carries a Q24 phase angle and a
// requested firing angle; each beat yields exactly one output beat with the
// cycle start and period start flags, the firing strobe, its late and between
// qualifiers and the held firing angle rebased onto the input angle. The
// control cycle is 2^CYCLE_BITS angle units; CYCLE_BEGIN_LIMIT and
// CYCLE_END_LIMIT set the begin and end regions used for wrap detection.
// Throughput is one beat per clock sustained while the output is taken. A beat
// waits in the input register and moves through the single decision stage into
// the output register when that register is free or drains; its result is then
// offered from the output register. The one-beat-per-clock rate is set by the
// state feedback loop: the folded angle, the fired-this-cycle flag and the held
// firing angle of one beat feed the decision of the next. The input side keeps
// taking beats while a result waits in the output register, until the input
// register is also full. Configuration is to be written through the plain write
// port only while no beat is in flight; the block itself does not enforce this.
// Register indexes are enable, min_angle, max_angle and sample_window, in that
// order.

`include "assert_macros.svh"

module phase_angle_firing_strobe
    import pafs_pkg::*;
#(
    parameter int CYCLE_BITS        = 23,
    parameter int CYCLE_BEGIN_LIMIT = 2097152,
    parameter int CYCLE_END_LIMIT   = 6291456
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [ANGLE_W-1:0]   i_cfg_wdata,
    // input stream
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [47:0]          i_s_tdata,   // phase_angle[23:0], request_angle[47:24]
    // output stream
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [31:0]               o_m_tdata    // cycle_start[0], period_start[1], fire[2],
                                                   // fired_late[3], fired_between[4],
                                                   // fire_angle[29:5], zero[31:30]
);

    t_cfg    w_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_out;

    logic               r_in_valid;
    logic [ANGLE_W-1:0] r_in_angle;
    logic [ANGLE_W-1:0] r_in_request;
    logic               r_out_valid;
    logic               w_in_take;
    logic               w_move;

    pafs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // beat leaves the input register when the output register is free or drains
    assign w_move     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_move;
    assign w_in_take  = i_s_tvalid && o_s_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_angle   <= i_s_tdata[23:0];
            r_in_request <= i_s_tdata[47:24];
        end
    end

    pafs_calc #(
        .CYCLE_BITS        (CYCLE_BITS),
        .CYCLE_BEGIN_LIMIT (CYCLE_BEGIN_LIMIT),
        .CYCLE_END_LIMIT   (CYCLE_END_LIMIT)
    ) u_calc (
        .i_phase_angle   (r_in_angle),
        .i_request_angle (r_in_request),
        .i_cfg           (w_cfg),
        .i_state         (r_state),
        .o_state         (n_state),
        .o_result        (n_result)
    );

    // block state advances exactly once per beat, when it enters the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_move) begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out.fire_angle, r_out.fired_between, r_out.fired_late,
                         r_out.fire, r_out.period_start, r_out.cycle_start};

    // a beat moved forward always shows up at the output
    `ASSERT_CLKRST(a_move_lands, i_clk, i_rst_n, w_move |=> r_out_valid, "beat lost on move")

    // a waiting input beat is neither dropped nor overwritten
    `ASSERT_CLKRST(a_in_hold, i_clk, i_rst_n,
        (r_in_valid && !w_move) |=> (r_in_valid && $stable(r_in_angle)
            && $stable(r_in_request)), "input beat overwritten")

    // a shown strobe matches the state it left behind
    `ASSERT_CLKRST(a_fire_state, i_clk, i_rst_n,
        (r_out_valid && r_out.fire) |-> (r_state.fired_this_cycle && r_state.prev_strobe
            && (r_state.held_fire_angle == r_out.fire_angle)), "strobe and state disagree")

endmodule

`default_nettype wire
